// ===== src/hpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared sizes and helpers of the multilevel page table unit.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int OFFSET_BITS = 4;
    localparam int LEVELS      = 2;
    // frame index of a table entry is taken as its low bits, so a power of two
    localparam int FRAMES      = 32;
    localparam int WORD_BITS   = 32;

    localparam int VA_W       = 12;
    localparam int DATA_W     = 32;
    localparam int PAGE_WORDS = 1 << OFFSET_BITS;
    localparam int FRAME_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PAGE_W     = OFFSET_BITS * LEVELS;
    localparam int PAGE_COUNT = 1 << PAGE_W;
    localparam int VM_BITS    = OFFSET_BITS * (LEVELS + 1);
    localparam int FADDR_W    = FRAME_W + OFFSET_BITS;
    localparam int SADDR_W    = PAGE_W + OFFSET_BITS;
    localparam int LV_W       = $clog2(LEVELS + 1);
    localparam int DEP_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [WORD_BITS-1:0]   ENTRY_EMPTY = '0;
    localparam logic [OFFSET_BITS-1:0] IDX_LAST    = OFFSET_BITS'(PAGE_WORDS - 1);
    localparam logic [DEP_W-1:0]       DEP_LAST    = DEP_W'(LEVELS - 1);

    typedef logic [FRAME_W-1:0]     t_frame;
    typedef logic [OFFSET_BITS-1:0] t_slot;
    typedef logic [PAGE_W-1:0]      t_page;
    typedef logic [FADDR_W-1:0]     t_faddr;
    typedef logic [WORD_BITS-1:0]   t_word;

    function automatic t_faddr faddr(input t_frame frame, input t_slot slot);
        return {frame, slot};
    endfunction

endpackage
`default_nettype wire

// ===== src/hpt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hpt_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [1 << ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/hierarchical_page_table_mmu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchical_page_table_mmu
// Page table walker with frame allocation, eviction to swap and page restore.
// ----------------------------------------------------------------------------
// After reset the frame memory is cleared, one word a cycle, all 512 words
// with busy high. An item is taken when start is high and busy is low; busy
// stays high until o_done pulses for one cycle with the result, and the
// receiver must take it then. Every table word touched costs one frame memory
// read, so time is set by the single read port: a mapped access reads one
// entry per level and then the data word, which a write stores as it is read
// and a read registers before the result; an address out of range gives its
// result in the cycle after it is taken. An allocation adds a depth-first
// search of the tables (run again when a page is evicted), a copy of each
// word of the victim page to swap and a fill of each word of the new frame.
module hierarchical_page_table_mmu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_mode,
    input  wire logic [11:0] i_virtual_address,
    input  wire logic [31:0] i_write_value,
    output logic             o_done,
    output logic             o_status,
    output logic [31:0]      o_read_data,
    output logic [1:0]       o_evictions
);

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_WALK_RD = 5'd2;
    localparam logic [4:0] S_WALK_EV = 5'd3;
    localparam logic [4:0] S_ZT_RD   = 5'd4;
    localparam logic [4:0] S_ZT_EV   = 5'd5;
    localparam logic [4:0] S_ZT_ADV  = 5'd6;
    localparam logic [4:0] S_VS_RD   = 5'd7;
    localparam logic [4:0] S_VS_EV   = 5'd8;
    localparam logic [4:0] S_VS_ADV  = 5'd9;
    localparam logic [4:0] S_EV_RD   = 5'd10;
    localparam logic [4:0] S_EV_WR   = 5'd11;
    localparam logic [4:0] S_EV_UNL  = 5'd12;
    localparam logic [4:0] S_FILL_RD = 5'd13;
    localparam logic [4:0] S_FILL_WR = 5'd14;
    localparam logic [4:0] S_LINK    = 5'd15;
    localparam logic [4:0] S_ACC_RD  = 5'd16;
    localparam logic [4:0] S_ACC_EV  = 5'd17;
    localparam logic [4:0] S_DONE    = 5'd18;

    localparam logic [hpt_pkg::LV_W-1:0] LV_ONE = hpt_pkg::LV_W'(1);

    logic [4:0]                          r_state;
    logic [hpt_pkg::FADDR_W-1:0]         r_clr;
    logic                                r_mode;
    logic [hpt_pkg::VA_W-1:0]            r_va;
    logic [31:0]                         r_wv;
    logic [hpt_pkg::LV_W-1:0]            r_lvl;
    hpt_pkg::t_frame                     r_table;
    hpt_pkg::t_frame                     r_nf;
    hpt_pkg::t_frame                     r_maxf;
    logic [hpt_pkg::DEP_W-1:0]           r_dep;
    hpt_pkg::t_frame                     r_cur  [hpt_pkg::LEVELS];
    hpt_pkg::t_slot                      r_idx  [hpt_pkg::LEVELS];
    logic                                r_allz [hpt_pkg::LEVELS];
    hpt_pkg::t_faddr                     r_lnk  [hpt_pkg::LEVELS];
    logic [hpt_pkg::PAGE_W:0]            r_best;
    hpt_pkg::t_frame                     r_vframe;
    hpt_pkg::t_page                      r_vpage;
    hpt_pkg::t_frame                     r_vpar;
    hpt_pkg::t_slot                      r_vslot;
    hpt_pkg::t_slot                      r_cnt;
    logic [hpt_pkg::PAGE_COUNT-1:0]      r_swv;
    logic                                r_status;
    logic [31:0]                         r_rdata;
    logic [1:0]                          r_evs;

    logic                        f_we;
    hpt_pkg::t_faddr             f_waddr;
    hpt_pkg::t_word              f_wdata;
    hpt_pkg::t_faddr             f_raddr;
    hpt_pkg::t_word              f_rdata;
    logic                        s_we;
    logic [hpt_pkg::SADDR_W-1:0] s_waddr;
    hpt_pkg::t_word              s_raddr_dummy;
    logic [hpt_pkg::SADDR_W-1:0] s_raddr;
    hpt_pkg::t_word              s_rdata;

    hpt_pkg::t_slot              c_walk_idx;
    hpt_pkg::t_frame             c_vf;
    logic                        c_vnz;
    hpt_pkg::t_page              c_page;
    hpt_pkg::t_page              c_target;
    hpt_pkg::t_page              c_diff;
    logic [hpt_pkg::PAGE_W:0]    c_wrap;
    logic [hpt_pkg::PAGE_W:0]    c_dist;
    logic [hpt_pkg::DEP_W-1:0]   c_dep_up;
    logic                        c_last;
    logic                        c_zt_hit;
    logic [63:0]                 c_rd64;
    logic [63:0]                 c_wv64;
    logic                        c_oor;

    assign s_raddr_dummy = '0;

    hpt_ram #(.ADDR_W(hpt_pkg::FADDR_W), .DATA_W(hpt_pkg::WORD_BITS)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    hpt_ram #(.ADDR_W(hpt_pkg::SADDR_W), .DATA_W(hpt_pkg::WORD_BITS)) u_swap_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (f_rdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    always_comb begin
        c_walk_idx = hpt_pkg::OFFSET_BITS'(r_va >> (hpt_pkg::OFFSET_BITS * int'(r_lvl)));
        c_vf       = f_rdata[hpt_pkg::FRAME_W-1:0];
        c_vnz      = f_rdata != hpt_pkg::ENTRY_EMPTY;
        c_target   = r_va[hpt_pkg::VM_BITS-1:hpt_pkg::OFFSET_BITS];
        c_page     = '0;
        for (int k = 0; k < hpt_pkg::LEVELS; k++) begin
            c_page = hpt_pkg::PAGE_W'({c_page, r_idx[k]});
        end
        // cyclic distance between the target page and a candidate leaf
        c_diff   = (c_target >= c_page) ? c_target - c_page : c_page - c_target;
        c_wrap   = (hpt_pkg::PAGE_W + 1)'(hpt_pkg::PAGE_COUNT) - {1'b0, c_diff};
        c_dist   = (c_wrap < {1'b0, c_diff}) ? c_wrap : {1'b0, c_diff};
        c_dep_up = r_dep + 1'b1;
        c_last   = r_idx[r_dep] == hpt_pkg::IDX_LAST;
        c_zt_hit = c_last && r_allz[r_dep] && (r_cur[r_dep] != r_table);
        c_rd64   = 64'(f_rdata);
        c_wv64   = 64'(signed'(i_write_value));
        c_oor    = (i_virtual_address >> hpt_pkg::VM_BITS) != '0;
    end

    always_comb begin
        f_we    = 1'b0;
        f_waddr = r_clr;
        f_wdata = '0;
        f_raddr = hpt_pkg::faddr(r_table, c_walk_idx);
        s_we    = 1'b0;
        s_waddr = {r_vpage, r_cnt};
        s_raddr = {c_target, r_cnt};
        unique case (r_state)
            S_CLR: begin
                f_we = 1'b1;
            end
            S_ZT_RD, S_VS_RD: begin
                f_raddr = hpt_pkg::faddr(r_cur[r_dep], r_idx[r_dep]);
            end
            S_ZT_ADV: begin
                // unlink the empty table that is being reused
                if (c_zt_hit) begin
                    f_we    = 1'b1;
                    f_waddr = r_lnk[r_dep];
                end
            end
            S_EV_RD: begin
                f_raddr = hpt_pkg::faddr(r_vframe, r_cnt);
            end
            S_EV_WR: begin
                s_we = 1'b1;
            end
            S_EV_UNL: begin
                f_we    = 1'b1;
                f_waddr = hpt_pkg::faddr(r_vpar, r_vslot);
            end
            S_FILL_WR: begin
                f_we    = 1'b1;
                f_waddr = hpt_pkg::faddr(r_nf, r_cnt);
                f_wdata = ((r_lvl == LV_ONE) && r_swv[c_target]) ? s_rdata : s_raddr_dummy;
            end
            S_LINK: begin
                f_we    = 1'b1;
                f_waddr = hpt_pkg::faddr(r_table, c_walk_idx);
                f_wdata = hpt_pkg::WORD_BITS'(r_nf);
            end
            S_ACC_RD: begin
                f_raddr = hpt_pkg::faddr(r_table, r_va[hpt_pkg::OFFSET_BITS-1:0]);
                f_waddr = f_raddr;
                f_we    = r_mode;
                f_wdata = hpt_pkg::WORD_BITS'(64'(signed'(r_wv)));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_swv   <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_mode   <= i_mode;
                        r_va     <= i_virtual_address;
                        r_wv     <= c_wv64[31:0];
                        r_lvl    <= hpt_pkg::LV_W'(hpt_pkg::LEVELS);
                        r_table  <= '0;
                        r_evs    <= '0;
                        r_rdata  <= '0;
                        r_status <= c_oor;
                        r_state  <= c_oor ? S_DONE : S_WALK_RD;
                    end
                end
                S_WALK_RD: begin
                    r_state <= S_WALK_EV;
                end
                S_WALK_EV: begin
                    if (c_vnz) begin
                        r_table <= c_vf;
                        if (r_lvl == LV_ONE) begin
                            r_state <= S_ACC_RD;
                        end else begin
                            r_lvl   <= r_lvl - 1'b1;
                            r_state <= S_WALK_RD;
                        end
                    end else begin
                        r_dep     <= '0;
                        r_cur[0]  <= '0;
                        r_idx[0]  <= '0;
                        r_allz[0] <= 1'b1;
                        r_lnk[0]  <= '0;
                        r_maxf    <= '0;
                        r_state   <= S_ZT_RD;
                    end
                end
                S_ZT_RD: begin
                    r_state <= S_ZT_EV;
                end
                S_ZT_EV: begin
                    if (c_vnz) begin
                        r_allz[r_dep] <= 1'b0;
                        if (c_vf > r_maxf) begin
                            r_maxf <= c_vf;
                        end
                    end
                    if (c_vnz && (r_dep != hpt_pkg::DEP_LAST)) begin
                        r_dep            <= c_dep_up;
                        r_cur[c_dep_up]  <= c_vf;
                        r_idx[c_dep_up]  <= '0;
                        r_allz[c_dep_up] <= 1'b1;
                        r_lnk[c_dep_up]  <= hpt_pkg::faddr(r_cur[r_dep], r_idx[r_dep]);
                        r_state          <= S_ZT_RD;
                    end else begin
                        r_state <= S_ZT_ADV;
                    end
                end
                S_ZT_ADV: begin
                    r_cnt <= '0;
                    priority if (!c_last) begin
                        r_idx[r_dep] <= r_idx[r_dep] + 1'b1;
                        r_state      <= S_ZT_RD;
                    end else if (c_zt_hit) begin
                        r_nf    <= r_cur[r_dep];
                        r_state <= S_FILL_RD;
                    end else if (r_dep != '0) begin
                        r_dep <= r_dep - 1'b1;
                    end else if ({1'b0, r_maxf} + 1'b1 < (hpt_pkg::FRAME_W + 1)'(hpt_pkg::FRAMES)) begin
                        r_nf    <= r_maxf + 1'b1;
                        r_state <= S_FILL_RD;
                    end else begin
                        // no free frame: look for a leaf page to evict
                        r_dep    <= '0;
                        r_cur[0] <= '0;
                        r_idx[0] <= '0;
                        r_best   <= '0;
                        r_vframe <= '0;
                        r_vpage  <= '0;
                        r_vpar   <= '0;
                        r_vslot  <= '0;
                        r_state  <= S_VS_RD;
                    end
                end
                S_VS_RD: begin
                    r_state <= S_VS_EV;
                end
                S_VS_EV: begin
                    if (c_vnz && (r_dep != hpt_pkg::DEP_LAST)) begin
                        r_dep           <= c_dep_up;
                        r_cur[c_dep_up] <= c_vf;
                        r_idx[c_dep_up] <= '0;
                        r_state         <= S_VS_RD;
                    end else begin
                        r_state <= S_VS_ADV;
                        if (c_vnz && (c_dist > r_best)) begin
                            r_best   <= c_dist;
                            r_vframe <= c_vf;
                            r_vpage  <= c_page;
                            r_vpar   <= r_cur[r_dep];
                            r_vslot  <= r_idx[r_dep];
                        end
                    end
                end
                S_VS_ADV: begin
                    r_cnt <= '0;
                    priority if (!c_last) begin
                        r_idx[r_dep] <= r_idx[r_dep] + 1'b1;
                        r_state      <= S_VS_RD;
                    end else if (r_dep != '0) begin
                        r_dep <= r_dep - 1'b1;
                    end else begin
                        r_state <= S_EV_RD;
                    end
                end
                S_EV_RD: begin
                    r_state <= S_EV_WR;
                end
                S_EV_WR: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= (r_cnt == hpt_pkg::IDX_LAST) ? S_EV_UNL : S_EV_RD;
                end
                S_EV_UNL: begin
                    r_swv[r_vpage] <= 1'b1;
                    r_nf           <= r_vframe;
                    r_cnt          <= '0;
                    if (r_evs != 2'd3) begin
                        r_evs <= r_evs + 1'b1;
                    end
                    r_state <= S_FILL_RD;
                end
                S_FILL_RD: begin
                    r_state <= S_FILL_WR;
                end
                S_FILL_WR: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= (r_cnt == hpt_pkg::IDX_LAST) ? S_LINK : S_FILL_RD;
                end
                S_LINK: begin
                    r_table <= r_nf;
                    if (r_lvl == LV_ONE) begin
                        r_state <= S_ACC_RD;
                    end else begin
                        r_lvl   <= r_lvl - 1'b1;
                        r_state <= S_WALK_RD;
                    end
                end
                S_ACC_RD: begin
                    r_state <= r_mode ? S_DONE : S_ACC_EV;
                end
                S_ACC_EV: begin
                    r_rdata <= c_rd64[31:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = r_state != S_IDLE;
    assign o_done      = r_state == S_DONE;
    assign o_status    = r_status;
    assign o_read_data = r_rdata;
    assign o_evictions = r_evs;

endmodule
`default_nettype wire

// ===== src/hpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_checker
// Port level checks of the page table unit, bound to the top level.
// ----------------------------------------------------------------------------
module hpt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic        o_status,
    input wire logic [31:0] o_read_data,
    input wire logic [1:0]  o_evictions
);

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result while idle");

    a_take_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("item not taken");

    a_free_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("still busy after result");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status |-> o_read_data == 32'd0 && o_evictions == 2'd0)
        else $error("failed item with data");

endmodule

bind hierarchical_page_table_mmu hpt_checker u_hpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_read_data (o_read_data),
    .o_evictions (o_evictions)
);
`default_nettype wire
